// ===== sv/hpj_pkg.sv =====
// ----------------------------------------------------------------------------
// hpj_pkg: shared types and constants of the heated-plate Jacobi sweep.
// Widths of the data words, register map codes and reset values of the
// configuration registers.
// ----------------------------------------------------------------------------
package hpj_pkg;

  localparam int VAL_W        = 19;
  localparam int IDX_W        = 12;
  localparam int DIM_W        = 13;
  localparam int ADDR_W       = 5;
  localparam int DATA_W       = 32;
  localparam int MAX_COLS_DEF = 4096;
  localparam int MAX_ROWS     = 4096;

  localparam logic [VAL_W-1:0] HOT_TEMP = 19'd256000;

  typedef enum logic [2:0] {
    REG_GRID_COLS    = 3'd0,
    REG_GRID_ROWS    = 3'd1,
    REG_TOP_VALUE    = 3'd2,
    REG_BOTTOM_VALUE = 3'd3,
    REG_LEFT_VALUE   = 3'd4,
    REG_RIGHT_VALUE  = 3'd5,
    REG_HOT_ROW      = 3'd6,
    REG_HOT_COL      = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [DIM_W-1:0] grid_cols;
    logic [DIM_W-1:0] grid_rows;
    logic [VAL_W-1:0] top_value;
    logic [VAL_W-1:0] bottom_value;
    logic [VAL_W-1:0] left_value;
    logic [VAL_W-1:0] right_value;
    logic [DIM_W-1:0] hot_row;
    logic [IDX_W-1:0] hot_col;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    grid_cols:    13'd1000,
    grid_rows:    13'd1000,
    top_value:    19'd0,
    bottom_value: 19'd25600,
    left_value:   19'd0,
    right_value:  19'd25600,
    hot_row:      13'd4096,
    hot_col:      12'd0
  };

  // Bit positions in the pending-result mask of the compute stage.
  localparam int RES_ABOVE = 0;
  localparam int RES_LEFT  = 1;
  localparam int RES_LAST  = 2;

endpackage

// ===== sv/hpj_regs.sv =====
// ----------------------------------------------------------------------------
// hpj_regs: configuration register file.
// APB-style slave with zero wait states holding the grid size, the four
// boundary temperatures and the hot-spot position.
// ----------------------------------------------------------------------------
module hpj_regs (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [hpj_pkg::ADDR_W-1:0]   paddr,
  input  logic [hpj_pkg::DATA_W-1:0]   pwdata,
  output logic [hpj_pkg::DATA_W-1:0]   prdata,
  output logic                         pready,
  output hpj_pkg::cfg_t                cfg
);

  logic             wr_en;
  hpj_pkg::reg_idx_t idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = hpj_pkg::reg_idx_t'(paddr[hpj_pkg::ADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= hpj_pkg::CFG_RESET;
    end else if (wr_en) begin
      unique case (idx)
        hpj_pkg::REG_GRID_COLS:    cfg.grid_cols    <= pwdata[hpj_pkg::DIM_W-1:0];
        hpj_pkg::REG_GRID_ROWS:    cfg.grid_rows    <= pwdata[hpj_pkg::DIM_W-1:0];
        hpj_pkg::REG_TOP_VALUE:    cfg.top_value    <= pwdata[hpj_pkg::VAL_W-1:0];
        hpj_pkg::REG_BOTTOM_VALUE: cfg.bottom_value <= pwdata[hpj_pkg::VAL_W-1:0];
        hpj_pkg::REG_LEFT_VALUE:   cfg.left_value   <= pwdata[hpj_pkg::VAL_W-1:0];
        hpj_pkg::REG_RIGHT_VALUE:  cfg.right_value  <= pwdata[hpj_pkg::VAL_W-1:0];
        hpj_pkg::REG_HOT_ROW:      cfg.hot_row      <= pwdata[hpj_pkg::DIM_W-1:0];
        hpj_pkg::REG_HOT_COL:      cfg.hot_col      <= pwdata[hpj_pkg::IDX_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      hpj_pkg::REG_GRID_COLS:    prdata = 32'(cfg.grid_cols);
      hpj_pkg::REG_GRID_ROWS:    prdata = 32'(cfg.grid_rows);
      hpj_pkg::REG_TOP_VALUE:    prdata = 32'(cfg.top_value);
      hpj_pkg::REG_BOTTOM_VALUE: prdata = 32'(cfg.bottom_value);
      hpj_pkg::REG_LEFT_VALUE:   prdata = 32'(cfg.left_value);
      hpj_pkg::REG_RIGHT_VALUE:  prdata = 32'(cfg.right_value);
      hpj_pkg::REG_HOT_ROW:      prdata = 32'(cfg.hot_row);
      hpj_pkg::REG_HOT_COL:      prdata = 32'(cfg.hot_col);
    endcase
  end

endmodule

// ===== sv/heat_plate_jacobi_sweep_top.sv =====
// ----------------------------------------------------------------------------
// heat_plate_jacobi_sweep_top: one Jacobi sweep of a heated plate.
// Interior cells enter in raster order; each output word is the truncated
// quarter of the cell's four neighbors, a row behind except in the last row.
// ----------------------------------------------------------------------------
// The block takes one cell word per clock unless stalled; each result goes
// through the compute stage and the output register. Every row but the last
// gives at most one result per cell, so the input takes up to one word per
// clock; in the last row a cell gives up to two results, and the last cell
// of the sweep up to three, so there the input stalls, as the single output
// register passes at most one word per clock. Two line memories of MAX_COLS
// entries hold the previous two rows; no clearing pass follows reset.
module heat_plate_jacobi_sweep_top #(
  parameter int MAX_COLS = hpj_pkg::MAX_COLS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [hpj_pkg::ADDR_W-1:0]  paddr,
  input  logic [hpj_pkg::DATA_W-1:0]  pwdata,
  output logic [hpj_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [hpj_pkg::VAL_W-1:0]   cell_value,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [hpj_pkg::VAL_W-1:0]   new_value,
  output logic [hpj_pkg::IDX_W-1:0]   out_row,
  output logic [hpj_pkg::IDX_W-1:0]   out_col,
  output logic                        frame_last
);

  localparam int CW = $clog2(MAX_COLS);
  localparam int NW = $clog2(MAX_COLS + 1);
  localparam int VW = hpj_pkg::VAL_W;
  localparam int RW = hpj_pkg::IDX_W;
  localparam int DW = hpj_pkg::DIM_W;

  hpj_pkg::cfg_t cfg;

  hpj_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Input side: position counters, grid clamping, hot spot.
  logic [CW-1:0] col_count;
  logic [RW-1:0] row_count;
  logic [31:0]   nc_wide;
  logic [NW-1:0] nc;
  logic [DW-1:0] nr;
  logic          restart;
  logic [RW-1:0] i0;
  logic [CW-1:0] j0;
  logic [CW-1:0] j0_next;
  logic          lastcol0;
  logic          lastrow0;
  logic          hot0;
  logic [VW-1:0] v0;
  logic          acc;

  always_comb begin
    nc_wide = 32'(cfg.grid_cols);
    if (nc_wide == 32'd0) begin
      nc_wide = 32'd1;
    end else if (nc_wide > 32'(MAX_COLS)) begin
      nc_wide = 32'(MAX_COLS);
    end
    nc = NW'(nc_wide);
    if (cfg.grid_rows == '0) begin
      nr = DW'(1);
    end else if (cfg.grid_rows > DW'(hpj_pkg::MAX_ROWS)) begin
      nr = DW'(hpj_pkg::MAX_ROWS);
    end else begin
      nr = cfg.grid_rows;
    end
  end

  assign restart  = (DW'(row_count) >= nr) || (NW'(col_count) >= nc);
  assign i0       = restart ? '0 : row_count;
  assign j0       = restart ? '0 : col_count;
  assign j0_next  = j0 + CW'(1);
  assign lastcol0 = (NW'(j0) + NW'(1)) == nc;
  assign lastrow0 = (DW'(i0) + DW'(1)) == nr;
  assign hot0     = (DW'(i0) == cfg.hot_row) && (32'(j0) == 32'(cfg.hot_col));
  assign v0       = hot0 ? hpj_pkg::HOT_TEMP : cell_value;
  assign acc      = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
    end else if (acc) begin
      if (lastcol0) begin
        col_count <= '0;
        row_count <= lastrow0 ? '0 : i0 + RW'(1);
      end else begin
        col_count <= j0_next;
        row_count <= i0;
      end
    end
  end

  // Line memories: mid_mem holds the last finished row, up_mem the one before.
  logic [VW-1:0] mid_mem [MAX_COLS];
  logic [VW-1:0] up_mem  [MAX_COLS];
  logic [VW-1:0] mid_rd0;
  logic [VW-1:0] mid_rd1;
  logic [VW-1:0] up_rd0;

  // Compute stage.
  logic          s1_valid;
  logic [2:0]    s1_pend;
  logic [VW-1:0] s1_v;
  logic [RW-1:0] s1_i;
  logic [CW-1:0] s1_j;
  logic          s1_lastcol;
  logic          s1_retire;
  logic          fwd_en;
  logic [CW-1:0] fwd_addr;
  logic [VW-1:0] fwd_mid;
  logic [VW-1:0] fwd_up;
  logic [VW-1:0] prev_cell;
  logic [VW-1:0] cur1;
  logic [VW-1:0] cur2;
  logic [CW-1:0] s1_j1;
  logic [VW-1:0] mid0;
  logic [VW-1:0] mid1;
  logic [VW-1:0] up0;

  always_ff @(posedge clk) begin
    if (acc) begin
      mid_rd0 <= mid_mem[j0];
      mid_rd1 <= mid_mem[j0_next];
      up_rd0  <= up_mem[j0];
    end
    if (s1_retire) begin
      mid_mem[s1_j] <= s1_v;
      up_mem[s1_j]  <= mid0;
    end
  end

  // A write retiring in the cycle of a read is not yet seen by that read.
  assign s1_j1 = s1_j + CW'(1);
  assign mid0  = (fwd_en && fwd_addr == s1_j)  ? fwd_mid : mid_rd0;
  assign up0   = (fwd_en && fwd_addr == s1_j)  ? fwd_up  : up_rd0;
  assign mid1  = (fwd_en && fwd_addr == s1_j1) ? fwd_mid : mid_rd1;

  logic [VW-1:0] op_up;
  logic [VW-1:0] op_dn;
  logic [VW-1:0] op_l;
  logic [VW-1:0] op_r;
  logic [RW-1:0] res_row;
  logic [RW-1:0] res_col;
  logic          res_last;
  logic [2:0]    pend_rest;
  logic [VW+1:0] sum;
  logic          out_load;

  always_comb begin
    priority if (s1_pend[hpj_pkg::RES_ABOVE]) begin
      op_up     = (s1_i == RW'(1)) ? cfg.top_value : up0;
      op_dn     = s1_v;
      op_l      = (s1_j != '0) ? prev_cell : cfg.left_value;
      op_r      = s1_lastcol ? cfg.right_value : mid1;
      res_row   = s1_i - RW'(1);
      res_col   = RW'(s1_j);
      res_last  = 1'b0;
      pend_rest = s1_pend & ~(3'b001 << hpj_pkg::RES_ABOVE);
    end else if (s1_pend[hpj_pkg::RES_LEFT]) begin
      op_up     = (s1_i == '0) ? cfg.top_value : prev_cell;
      op_dn     = cfg.bottom_value;
      op_l      = (s1_j >= CW'(2)) ? cur2 : cfg.left_value;
      op_r      = s1_v;
      res_row   = s1_i;
      res_col   = RW'(s1_j) - RW'(1);
      res_last  = 1'b0;
      pend_rest = s1_pend & ~(3'b001 << hpj_pkg::RES_LEFT);
    end else begin
      op_up     = (s1_i == '0) ? cfg.top_value : mid0;
      op_dn     = cfg.bottom_value;
      op_l      = (s1_j != '0) ? cur1 : cfg.left_value;
      op_r      = cfg.right_value;
      res_row   = s1_i;
      res_col   = RW'(s1_j);
      res_last  = 1'b1;
      pend_rest = '0;
    end
    sum = (VW+2)'(op_up) + (VW+2)'(op_dn) + (VW+2)'(op_l) + (VW+2)'(op_r);
  end

  assign out_load  = s1_valid && (s1_pend != '0) && (!out_valid || !out_stall);
  assign s1_retire = s1_valid && ((s1_pend == '0) || (out_load && pend_rest == '0));
  assign in_stall  = s1_valid && !s1_retire;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s1_pend  <= '0;
      fwd_en   <= 1'b0;
    end else if (acc) begin
      s1_valid <= 1'b1;
      s1_pend[hpj_pkg::RES_ABOVE] <= (i0 != '0);
      s1_pend[hpj_pkg::RES_LEFT]  <= lastrow0 && (j0 != '0);
      s1_pend[hpj_pkg::RES_LAST]  <= lastrow0 && lastcol0;
      fwd_en   <= s1_retire;
    end else begin
      if (s1_retire) begin
        s1_valid <= 1'b0;
      end
      if (out_load) begin
        s1_pend <= pend_rest;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_v       <= v0;
      s1_i       <= i0;
      s1_j       <= j0;
      s1_lastcol <= lastcol0;
      fwd_addr   <= s1_j;
      fwd_mid    <= s1_v;
      fwd_up     <= mid0;
    end
    if (s1_retire) begin
      prev_cell <= mid0;
      cur1      <= s1_v;
      cur2      <= cur1;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      new_value  <= sum[VW+1:2];
      out_row    <= res_row;
      out_col    <= res_col;
      frame_last <= res_last;
    end
  end

  // A cell waiting for the output register stays put.
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_retire |=> s1_valid && $stable(s1_v) && $stable(s1_j))
    else $error("compute stage changed while waiting");

  // Pending results only exist for an occupied compute stage.
  a_pend_valid: assert property (@(posedge clk) disable iff (rst)
    !s1_valid |-> s1_pend == '0)
    else $error("pending results without a cell");

  // The input is held back only by an occupied compute stage.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> s1_valid && s1_pend != '0)
    else $error("input stalled without a cause");

  // A result is loaded only into a free or draining output register.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |-> !out_load)
    else $error("output word overwritten while stalled");

endmodule
